// ----- rtl/assert_macros.svh -----
// Assertion macros for RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while arst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication, sampled on clk, masked while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ----- rtl/sapq_pkg.sv -----
// Types and constants shared by the sorted-array priority queue.
package sapq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int DATA_W      = 32;
	localparam int FILL_W      = 4;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] item_priority;
	} in_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] out_value;
		logic [FILL_W-1:0]        fill_count;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;  // capture the input beat
		logic exec;  // apply the held item, load the result register
	} cmd_t;

endpackage

// ----- rtl/sapq_ctrl.sv -----
// Handshake controller: accepts a beat, schedules execution, owns out_valid.
module sapq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output sapq_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && in_ready;
	// result register must be empty or draining this cycle
	assign cmd.exec  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.exec) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/sapq_dp.sv -----
// Datapath: sorted cell array, entry count, input and result registers.
module sapq_dp #(
	parameter int Depth = sapq_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sapq_pkg::cmd_t cmd,
	input  sapq_pkg::in_t  in_data,
	output sapq_pkg::out_t out_data
);

	localparam int CNT_W = $clog2(Depth + 1);
	localparam int IDX_W = $clog2(Depth);

	sapq_pkg::in_t  item_q;
	sapq_pkg::out_t res_q;
	sapq_pkg::out_t res_nxt;

	logic signed [sapq_pkg::DATA_W-1:0] val_q  [Depth];
	logic signed [sapq_pkg::DATA_W-1:0] prio_q [Depth];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] tail_idx;

	logic [Depth-1:0] lt;       // occupied and lower priority than the new one
	logic [Depth-1:0] take_new; // cell receives the new entry
	logic             full;
	logic             empty;
	logic             do_enq;
	logic             do_deq;

	assign full     = (count_q == CNT_W'(Depth));
	assign empty    = (count_q == '0);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign tail_idx = cnt_m1[IDX_W-1:0];
	assign do_enq   = cmd.exec && (item_q.operation == sapq_pkg::OP_ENQ) && !full;
	assign do_deq   = cmd.exec && (item_q.operation == sapq_pkg::OP_DEQ) && !empty;

	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (prio_q[i] < item_q.item_priority);
		end
		for (int i = 0; i < Depth; i++) begin
			if (i == 0) begin
				take_new[i] = lt[i] || (count_q == '0);
			end else begin
				take_new[i] = !lt[i-1] && (lt[i] || (CNT_W'(i) == count_q));
			end
		end
	end

	// every cell decides alone: shift from its neighbor, take new, or hold
	always_ff @(posedge clk) begin
		if (do_enq) begin
			for (int i = 0; i < Depth; i++) begin
				if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
					val_q[i]  <= val_q[(i > 0) ? i - 1 : 0];
					prio_q[i] <= prio_q[(i > 0) ? i - 1 : 0];
				end else if (take_new[i]) begin
					val_q[i]  <= item_q.item_value;
					prio_q[i] <= item_q.item_priority;
				end
			end
		end
	end

	always_comb begin
		count_nxt         = count_q;
		res_nxt.out_value = '0;
		res_nxt.status    = sapq_pkg::ST_ENQ;
		unique case (item_q.operation)
			sapq_pkg::OP_ENQ: begin
				if (full) begin
					res_nxt.status = sapq_pkg::ST_FULL;
				end else begin
					res_nxt.status = sapq_pkg::ST_ENQ;
					count_nxt      = count_q + CNT_W'(1);
				end
			end
			sapq_pkg::OP_DEQ: begin
				if (empty) begin
					res_nxt.status = sapq_pkg::ST_EMPTY;
				end else begin
					res_nxt.status    = sapq_pkg::ST_DEQ;
					res_nxt.out_value = val_q[tail_idx];
					count_nxt         = cnt_m1;
				end
			end
			default: begin
				res_nxt.status = sapq_pkg::ST_ENQ;
			end
		endcase
		res_nxt.fill_count = sapq_pkg::FILL_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_enq || do_deq) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			res_q <= res_nxt;
		end
	end

	assign out_data = res_q;

endmodule

// ----- rtl/sorted_array_priority_queue.sv -----
// Top level of the sorted-array priority queue: controller plus cell datapath.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_data  (operation, item_value, item_priority)
//   out      out  out_valid / out_ready  out_data (status, out_value, fill_count)
//
// Each beat is captured first, then all cells update at once; input waits meanwhile.
// The update waits while an unread result sits in the output register; the next
// input beat is still taken while that result waits.
// arst_n clears the count and handshake state; cell contents are left as is.
// Only slots below the count are ever read, so stale cells never show up.
`include "assert_macros.svh"

module sorted_array_priority_queue #(
	parameter int QueueDepth = sapq_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sapq_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sapq_pkg::out_t out_data
);

	sapq_pkg::cmd_t cmd;

	// Controller: one item in flight, result register acts as the skid stage.
	sapq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath: each cell compares its priority with the new one in parallel,
	// lower entries move one slot toward the tail, the tail is read on dequeue.
	sapq_dp #(
		.Depth (QueueDepth)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

	// a captured beat blocks the input until it has executed
	`ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// a rejected dequeue can only come from an empty queue
	`ASSERT_IMPL(a_empty_fill, out_valid && out_data.status == sapq_pkg::ST_EMPTY,
		out_data.fill_count == '0)
	// a rejected enqueue reports a full queue
	`ASSERT_IMPL(a_full_fill, out_valid && out_data.status == sapq_pkg::ST_FULL,
		out_data.fill_count == sapq_pkg::FILL_W'(QueueDepth))

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sorted-array priority queue.
module tb_top;
	import sapq_pkg::*;

	// Longest receiver hold-off, in cycles; the watchdog limit sits well above it
	// plus the longest sender gap.
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_OPEN,       // always ready
		RX_COIN,       // ready half the time
		RX_SPARSE,     // ready one cycle in four on average
		RX_ALTERNATE   // ready every other pair of cycles
	} rx_mode_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	sorted_array_priority_queue #(
		.QueueDepth(QUEUE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Queue model: entries sorted by descending signed priority, slot 0 highest; dequeue takes the tail.
	// Only slots below the count are ever looked at.
	// ---------------------------------------------------------------------
	logic signed [DATA_W-1:0] pq_value [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] pq_prio  [QUEUE_DEPTH];
	int                       pq_count = 0;

	// Results owed by the block, oldest first.
	out_t owed_results[$];

	function automatic out_t sorted_queue_apply(input in_t beat);
		out_t                     result;
		int                       pos;
		logic signed [DATA_W-1:0] new_prio;
		result   = '0;
		new_prio = beat.item_priority;
		if (beat.operation == OP_ENQ) begin
			if (pq_count >= QUEUE_DEPTH) begin
				result.status = ST_FULL;
			end else begin
				// strictly lower priorities slide toward the tail; equal ones stay ahead
				pos = pq_count;
				while (pos > 0 && pq_prio[pos-1] < new_prio) begin
					pq_value[pos] = pq_value[pos-1];
					pq_prio[pos]  = pq_prio[pos-1];
					pos--;
				end
				pq_value[pos] = beat.item_value;
				pq_prio[pos]  = new_prio;
				pq_count++;
				result.status = ST_ENQ;
			end
		end else begin
			if (pq_count == 0) begin
				result.status = ST_EMPTY;
			end else begin
				pq_count--;
				result.out_value = pq_value[pq_count];
				result.status    = ST_DEQ;
			end
		end
		result.fill_count = pq_count[FILL_W-1:0];
		return result;
	endfunction

	function automatic in_t make_beat(input op_t op, input logic signed [DATA_W-1:0] value,
			input logic signed [DATA_W-1:0] prio);
		in_t beat;
		beat.operation     = op;
		beat.item_value    = value;
		beat.item_priority = prio;
		return beat;
	endfunction

	// Priorities lean on a narrow band so that ties are frequent.
	function automatic logic signed [DATA_W-1:0] rand_priority();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $signed($urandom_range(0, 4)) - 2;
			4: begin
				case ($urandom_range(0, 3))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 15))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return -1;
			default: return $urandom;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them.
	// Every task here starts and ends at a falling edge.
	// ---------------------------------------------------------------------
	int burst_left = 0;
	int beats_sent = 0;

	task automatic send_beat(input in_t beat);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
			                                       : $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		owed_results.push_back(sorted_queue_apply(beat));
		beats_sent++;
		@(negedge clk);
	endtask

	// Sender pauses until every owed result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (owed_results.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Receiver: its own stall pattern, plus a long hold-off on request.
	// ---------------------------------------------------------------------
	logic hold_req      = 1'b0;
	int   holdoffs_done = 0;

	initial begin
		rx_mode_t mode;
		int       phase_left;
		int       tick;
		mode       = RX_OPEN;
		phase_left = 0;
		tick       = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holdoffs_done++;
			end else begin
				if (phase_left == 0) begin
					mode       = rx_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(10, 80);
				end
				phase_left--;
				tick++;
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= tick[1];
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result checker, field by field against the oldest owed result.
	// ---------------------------------------------------------------------
	int fail_count    = 0;
	int results_seen  = 0;
	int full_rejects  = 0;
	int empty_rejects = 0;
	int dequeues      = 0;
	int peak_fill     = 0;

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (owed_results.size() == 0) begin
				$error("result beat with nothing owed: status %0d value %0d fill %0d",
					out_data.status, out_data.out_value, out_data.fill_count);
				fail_count++;
			end else begin
				want = owed_results.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					fail_count++;
				end
				if (out_data.out_value !== want.out_value) begin
					$error("out_value: expected %0d, got %0d", want.out_value,
						out_data.out_value);
					fail_count++;
				end
				if (out_data.fill_count !== want.fill_count) begin
					$error("fill_count: expected %0d, got %0d", want.fill_count,
						out_data.fill_count);
					fail_count++;
				end
				case (want.status)
					ST_FULL:  full_rejects++;
					ST_EMPTY: empty_rejects++;
					ST_DEQ:   dequeues++;
					default:  ;
				endcase
				if (int'(want.fill_count) > peak_fill) peak_fill = int'(want.fill_count);
			end
		end
	end

	// Watchdog: too long with no beat moving on either side ends the run.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Dequeue on an empty queue; the data fields are junk and must be ignored.
	task automatic test_empty_dequeue();
		send_beat(make_beat(OP_DEQ, '1, '1));
		send_beat(make_beat(OP_DEQ, '0, WORD_MIN));
	endtask

	// Fill with extreme values and priorities including ties, overflow twice,
	// then drain past empty. Dequeue order exposes the tie rule.
	task automatic test_fill_and_overflow();
		send_beat(make_beat(OP_ENQ, WORD_MAX, 0));
		send_beat(make_beat(OP_ENQ, WORD_MIN, WORD_MAX));
		send_beat(make_beat(OP_ENQ, -1, WORD_MIN));
		send_beat(make_beat(OP_ENQ, 1, 0));          // ties with the first entry
		send_beat(make_beat(OP_ENQ, 0, -1));
		send_beat(make_beat(OP_ENQ, 5, 1));
		send_beat(make_beat(OP_ENQ, 6, WORD_MIN));   // ties at the bottom
		send_beat(make_beat(OP_ENQ, 7, 0));          // third tie at zero
		send_beat(make_beat(OP_ENQ, 99, WORD_MAX));  // full: rejected
		send_beat(make_beat(OP_ENQ, '1, '1));        // full: rejected
		repeat (QUEUE_DEPTH + 1) send_beat(make_beat(OP_DEQ, $urandom, $urandom));
	endtask

	// Receiver holds off while the sender keeps offering: input must stall.
	task automatic test_receiver_holdoff();
		int i;
		hold_req = 1'b1;
		for (i = 0; i < 12; i++) begin
			if (i < 9) send_beat(make_beat(OP_ENQ, rand_word(), rand_priority()));
			else send_beat(make_beat(OP_DEQ, $urandom, $urandom));
		end
		wait_drained();
	endtask

	// Segments with different enqueue bias walk the fill level between empty
	// and full; a drain pause is thrown in now and then.
	task automatic test_random_traffic(input int n_items);
		int enq_pct;
		int seg_left;
		int i;
		in_t beat;
		enq_pct  = 50;
		seg_left = 0;
		for (i = 0; i < n_items; i++) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 3))
					0: enq_pct = 15;
					1: enq_pct = 50;
					2: enq_pct = 85;
					default: enq_pct = 97;
				endcase
				seg_left = $urandom_range(8, 60);
			end
			seg_left--;
			if ($urandom_range(1, 100) <= enq_pct)
				beat = make_beat(OP_ENQ, rand_word(), rand_priority());
			else
				beat = make_beat(OP_DEQ, $urandom, $urandom);
			send_beat(beat);
			if (i % 350 == 349) wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_dequeue();
		test_fill_and_overflow();
		test_receiver_holdoff();
		test_random_traffic(1420);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d input beats and %0d results (%0d dequeues, peak fill %0d).",
			beats_sent, results_seen, dequeues, peak_fill);
		$display("Rejections seen: %0d on full, %0d on empty; %0d receiver hold-offs.",
			full_rejects, empty_rejects, holdoffs_done);
		if (fail_count == 0 && owed_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sorted_array_priority_queue.f -----
+incdir+rtl
rtl/sapq_pkg.sv
rtl/sapq_ctrl.sv
rtl/sapq_dp.sv
rtl/sorted_array_priority_queue.sv
tb/tb_top.sv
